/* src/b64se_pkg.sv */
// Shared types, constants and the character mapping of the Base64 stream encoder.
package b64se_pkg;

  // Default depth of the job queue between front and back
  localparam int unsigned JobQueueDepth = 2;

  // Alphabet anchors and special characters
  localparam logic [7:0] CharUpperA = 8'h41;  // 'A'
  localparam logic [7:0] CharLowerA = 8'h61;  // 'a'
  localparam logic [7:0] CharDigit0 = 8'h30;  // '0'
  localparam logic [7:0] CharPlus   = 8'h2B;  // '+'
  localparam logic [7:0] CharSlash  = 8'h2F;  // '/'
  localparam logic [7:0] CharPad    = 8'h3D;  // '='

  // Sextet range boundaries
  localparam logic [5:0] SextetLowerStart = 6'd26;
  localparam logic [5:0] SextetDigitStart = 6'd52;
  localparam logic [5:0] SextetPlus       = 6'd62;

  // Position of the next byte within its three-byte group
  typedef enum logic [1:0] {
    PhaseFirst  = 2'd0,
    PhaseSecond = 2'd1,
    PhaseThird  = 2'd2
  } phase_e;

  // Input transaction payload
  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  // Output transaction payload
  typedef struct packed {
    logic [7:0] code_char;
    logic       end_of_text;
  } out_item_t;

  // Characters produced by one input byte
  typedef struct packed {
    logic [3:0][7:0] chars;
    logic [1:0]      last_idx;
    logic            final_job;
  } job_t;

  // Map a sextet onto the standard alphabet
  function automatic logic [7:0] sextet_char(logic [5:0] v);
    logic [7:0] w;
    logic [7:0] c;
    w = {2'b00, v};
    if (v < SextetLowerStart) begin
      c = CharUpperA + w;
    end else if (v < SextetDigitStart) begin
      c = CharLowerA + (w - {2'b00, SextetLowerStart});
    end else if (v < SextetPlus) begin
      c = CharDigit0 + (w - {2'b00, SextetDigitStart});
    end else if (v == SextetPlus) begin
      c = CharPlus;
    end else begin
      c = CharSlash;
    end
    return c;
  endfunction

endpackage

/* src/base64_stream_encoder.sv */
// Top level of the streaming Base64 encoder.
//
//  channel | dir | handshake                  | payload
//  --------+-----+----------------------------+-----------------------------------
//  in      | in  | in_valid_i / in_ready_o    | in_item_i  (data_byte, final_byte)
//  out     | out | out_valid_o / out_ready_i  | out_item_o (code_char, end_of_text)
//
// Each byte yields 1 to 4 characters, four for a whole three-byte group; the output
// sends one character per cycle while out_ready_i is high and a job is waiting.
// The first character of a byte passes through the job queue, then the output register.
// Bytes are taken while the job queue has room, also while the output stalls.
// Reset returns to the start of a group with an empty queue and no output.
module base64_stream_encoder
  import b64se_pkg::*;
#(
  parameter int unsigned JobDepth = JobQueueDepth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic push_valid, push_ready;
  job_t push_job;
  logic pop_valid, pop_ready;
  job_t pop_job;

  b64se_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .job_valid_o (push_valid),
    .job_ready_i (push_ready),
    .job_o       (push_job)
  );

  b64se_fifo #(
    .Depth (JobDepth)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_job),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_job)
  );

  b64se_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (pop_valid),
    .job_ready_o (pop_ready),
    .job_i       (pop_job),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

/* src/b64se_front.sv */
// Front end: takes bytes, tracks group position and leftover bits, builds character jobs.
module b64se_front
  import b64se_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     job_valid_o,
  input  logic     job_ready_i,
  output job_t     job_o
);

  phase_e     phase_q, phase_d;
  logic [3:0] left_q, left_d;
  logic       in_fire;
  logic [7:0] b;
  logic       fin;

  assign in_ready_o  = job_ready_i;
  assign job_valid_o = in_valid_i;
  assign in_fire     = in_valid_i && job_ready_i;
  assign b           = in_item_i.data_byte;
  assign fin         = in_item_i.final_byte;

  // Hold group position and leftover bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhaseFirst;
      left_q  <= 4'd0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      left_q  <= left_d;
    end
  end

  // Split the byte into sextets, add padding on a final byte that ends a partial group
  always_comb begin
    job_o.chars     = {4{CharPad}};
    job_o.last_idx  = 2'd0;
    job_o.final_job = fin;
    phase_d         = PhaseFirst;
    left_d          = 4'd0;
    unique case (phase_q)
      PhaseSecond: begin
        job_o.chars[0] = sextet_char({left_q[1:0], b[7:4]});
        left_d         = b[3:0];
        phase_d        = PhaseThird;
        if (fin) begin
          job_o.chars[1] = sextet_char({b[3:0], 2'b00});
          job_o.chars[2] = CharPad;
          job_o.last_idx = 2'd2;
        end
      end
      PhaseThird: begin
        job_o.chars[0] = sextet_char({left_q, b[7:6]});
        job_o.chars[1] = sextet_char(b[5:0]);
        job_o.last_idx = 2'd1;
        left_d         = 4'd0;
        phase_d        = PhaseFirst;
      end
      default: begin
        job_o.chars[0] = sextet_char(b[7:2]);
        left_d         = {2'b00, b[1:0]};
        phase_d        = PhaseSecond;
        if (fin) begin
          job_o.chars[1] = sextet_char({b[1:0], 4'b0000});
          job_o.chars[2] = CharPad;
          job_o.chars[3] = CharPad;
          job_o.last_idx = 2'd3;
        end
      end
    endcase
    // Restart the group after the last byte
    if (fin) begin
      phase_d = PhaseFirst;
      left_d  = 4'd0;
    end
  end

endmodule

/* src/b64se_fifo.sv */
// Short job queue between front and back end.
module b64se_fifo
  import b64se_pkg::*;
#(
  parameter int unsigned Depth = JobQueueDepth
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  job_t push_data_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output job_t pop_data_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  job_t            mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != FullCnt);
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_ptr_q];

  // Write accepted jobs
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* src/b64se_back.sv */
// Back end: sends job characters through an output register, one per unstalled cycle.
module b64se_back
  import b64se_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      job_valid_i,
  output logic      job_ready_o,
  input  job_t      job_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic [1:0] idx_q;
  logic       out_valid_q;
  out_item_t  out_q;
  logic       load;
  logic       job_done;

  assign load        = job_valid_i && (!out_valid_q || out_ready_i);
  assign job_done    = (idx_q == job_i.last_idx);
  assign job_ready_o = load && job_done;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // Load the next character into the output register
  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q.code_char   <= job_i.chars[idx_q];
      out_q.end_of_text <= job_i.final_job && job_done;
    end
  end

  // Step through the job and track output occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        idx_q <= job_done ? 2'd0 : idx_q + 2'd1;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Character index stays within the current job
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_valid_i |-> idx_q <= job_i.last_idx)
    else $error("character index beyond job length");

  // A finished job leaves the index at the start
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    job_ready_o |=> idx_q == 2'd0)
    else $error("index not restarted after job");

  // The end-of-text character is always the last one of its job
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.end_of_text |-> idx_q == 2'd0)
    else $error("end of text shown mid-job");

endmodule

/* verif/base64_stream_encoder_tb.sv */
// Self-checking testbench of the streaming Base64 encoder with a scoreboard class.
`timescale 1ns / 100ps

import b64se_pkg::*;

// Standard alphabet, index 0 is the leftmost character
localparam logic [0:63][7:0] Alphabet =
  "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

// Encode accepted bytes into expected characters and check the output against them
class char_scoreboard;
  phase_e     phase;
  logic [3:0] leftover;
  out_item_t  expected_chars[$];
  int         error_count;
  int         chars_seen;

  function new();
    phase       = PhaseFirst;
    leftover    = '0;
    error_count = 0;
    chars_seen  = 0;
  endfunction

  function logic [7:0] to_char(logic [5:0] sextet);
    return Alphabet[sextet];
  endfunction

  function int pending();
    return expected_chars.size();
  endfunction

  // Print one mismatch line and count it
  task report(string msg);
    $display("[%0t] MISMATCH char %0d: %s", $realtime, chars_seen, msg);
    error_count++;
  endtask

  // Work out the characters that one accepted byte completes
  function void note_byte(in_item_t item);
    logic [7:0] b;
    logic [7:0] chars[4];
    int         n;
    out_item_t  ch_item;
    b = item.data_byte;
    n = 0;
    case (phase)
      PhaseSecond: begin
        chars[0] = to_char({leftover[1:0], b[7:4]});
        leftover = b[3:0];
        phase    = PhaseThird;
        n        = 1;
        if (item.final_byte) begin
          chars[1] = to_char({b[3:0], 2'b00});
          chars[2] = CharPad;
          n        = 3;
        end
      end
      PhaseThird: begin
        chars[0] = to_char({leftover, b[7:6]});
        chars[1] = to_char(b[5:0]);
        leftover = '0;
        phase    = PhaseFirst;
        n        = 2;
      end
      default: begin
        chars[0] = to_char(b[7:2]);
        leftover = {2'b00, b[1:0]};
        phase    = PhaseSecond;
        n        = 1;
        if (item.final_byte) begin
          chars[1] = to_char({b[1:0], 4'b0000});
          chars[2] = CharPad;
          chars[3] = CharPad;
          n        = 4;
        end
      end
    endcase
    // Start a fresh group after the end of a message
    if (item.final_byte) begin
      phase    = PhaseFirst;
      leftover = '0;
    end
    for (int i = 0; i < n; i++) begin
      ch_item.code_char   = chars[i];
      ch_item.end_of_text = item.final_byte && (i == n - 1);
      expected_chars.push_back(ch_item);
    end
  endfunction

  // Compare one accepted character with the oldest expectation
  task check_char(out_item_t got);
    out_item_t want;
    if (expected_chars.size() == 0) begin
      report($sformatf("unexpected char 0x%02h end %0b", got.code_char, got.end_of_text));
    end else begin
      want = expected_chars.pop_front();
      if (got.code_char !== want.code_char) begin
        report($sformatf("code_char 0x%02h, want 0x%02h", got.code_char, want.code_char));
      end
      if (got.end_of_text !== want.end_of_text) begin
        report($sformatf("end_of_text %0b, want %0b", got.end_of_text, want.end_of_text));
      end
    end
    chars_seen++;
  endtask
endclass

module testbench;

  localparam int RandomItems   = 455;
  localparam int CalmAfter     = 400;
  localparam int HoldOffAfter  = 100;
  localparam int HoldOffCycles = 300;
  localparam int WatchdogLimit = 3000;
  localparam int DrainCycles   = 8;

  logic      clk_i       = 1'b0;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i   = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  char_scoreboard sb = new();

  bit calm          = 1'b0;
  bit hold_off_req  = 1'b0;
  bit hold_off_done = 1'b0;
  int tx_idle_pct   = 0;
  int rx_idle_pct   = 0;
  int items_sent    = 0;
  int idle_cycles   = 0;

  base64_stream_encoder u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  // Clock, 10 ns period
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Check outputs, then record accepted bytes
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        sb.check_char(out_item_o);
      end
      if (in_valid_i && in_ready_o) begin
        sb.note_byte(in_item_i);
      end
    end
  end

  // Offer one byte, optionally after an idle burst, and hold it until accepted
  task automatic send_byte(input logic [7:0] b, input logic fin);
    in_item_t item;
    item.data_byte  = b;
    item.final_byte = fin;
    if (!calm && tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
  endtask

  // Send one message of random content
  task automatic send_random_message(input int len);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 9))
        0:       b = 8'h00;
        1:       b = 8'hFF;
        default: b = 8'($urandom);
      endcase
      send_byte(b, i == len - 1);
    end
  endtask

  // Receiver: idle bursts, one long hold-off, no idling at the end
  initial begin
    forever begin
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 2))
          0:       rx_idle_pct = 0;
          1:       rx_idle_pct = 10;
          default: rx_idle_pct = 35;
        endcase
      end
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else if (!calm && rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  // Watchdog: end the run after too many cycles without any transaction
  initial begin
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Main stimulus
  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: final byte in each group position, extremes, '+' and '/'
    send_byte(8'h4D, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b1);
    send_byte(8'h4D, 1'b0);
    send_byte(8'h61, 1'b0);
    send_byte(8'h6E, 1'b1);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFB, 1'b0);
    send_byte(8'hEF, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h04, 1'b1);

    // Random messages, mostly short, a few long ones
    items_sent = 0;
    while (items_sent < RandomItems) begin
      case ($urandom_range(0, 2))
        0:       tx_idle_pct = 0;
        1:       tx_idle_pct = 15;
        default: tx_idle_pct = 40;
      endcase
      // Request the long receiver hold-off exactly once
      if (!hold_off_done && items_sent >= HoldOffAfter) begin
        hold_off_req  = 1'b1;
        hold_off_done = 1'b1;
      end
      if (items_sent >= CalmAfter) begin
        calm = 1'b1;
      end
      if ($urandom_range(0, 15) == 0) begin
        send_random_message($urandom_range(12, 40));
      end else begin
        send_random_message($urandom_range(1, 10));
      end
    end
    in_valid_i <= 1'b0;

    // Drain the outstanding characters, then watch for strays
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.pending() != 0) begin
      sb.report("characters still outstanding at the end");
    end

    if (sb.error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
